[rtl/itf_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// itf_pkg
// Shared types, constants and helpers for the instantaneous trendline filter.
// ----------------------------------------------------------------------------
package itf_pkg;

  localparam int PRICE_W = 32;
  localparam int TREND_W = 40;
  localparam int ALPHA_W = 16;
  localparam int IDX_W   = 3;
  localparam int COEF_W  = 22;
  localparam int MUL_A_W = 41;
  localparam int MUL_B_W = 23;
  localparam int PROD_W  = MUL_A_W + MUL_B_W;
  localparam int RND_W   = 44;
  localparam int COEF_FRAC = 20;

  localparam logic [ALPHA_W-1:0] ALPHA_RESET    = 16'd4588;
  localparam logic [IDX_W-1:0]   WARMUP_SAMPLES = 3'd6;
  localparam logic [IDX_W-1:0]   IDX_FIR_START  = 3'd2;
  localparam logic [IDX_W-1:0]   IDX_TRIG_START = 3'd4;
  localparam logic [IDX_W-1:0]   IDX_MAX        = 3'd7;

  localparam logic signed [TREND_W-1:0] TREND_MAX = 40'sh7FFFFFFFFF;
  localparam logic signed [TREND_W-1:0] TREND_MIN = 40'sh8000000000;
  localparam logic signed [RND_W-1:0]   SAT_HI    = 44'sh07FFFFFFFFF;
  localparam logic signed [RND_W-1:0]   SAT_LO    = 44'shF8000000000;
  localparam logic signed [PROD_W-1:0]  ROUND_BIAS = 64'sd524288;

  typedef struct packed {
    logic [PRICE_W-1:0] median_price;
    logic               first;
  } in_t;

  typedef struct packed {
    logic signed [TREND_W-1:0] trend_value;
    logic signed [TREND_W-1:0] trigger_value;
    logic                      trigger_valid;
  } out_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SQA,
    ST_SQB,
    ST_MAC,
    ST_LAST,
    ST_ROUND,
    ST_EMIT
  } state_t;

  // multiplier operand pair
  typedef enum logic [2:0] {
    MS_ALPHA,
    MS_OMA,
    MS_C0,
    MS_C1,
    MS_C2,
    MS_C3,
    MS_C4
  } mul_sel_t;

  typedef enum logic [1:0] {
    ACC_HOLD,
    ACC_CLEAR,
    ACC_ADD,
    ACC_SUB
  } acc_op_t;

  typedef struct packed {
    logic     ready;
    logic     accept;
    mul_sel_t mul_sel;
    logic     ld_coef_a;
    logic     ld_coef_b;
    acc_op_t  acc_op;
    logic     ld_round;
    logic     emit;
  } ctl_t;

  typedef struct packed {
    logic go_iir;
    logic has_result;
    logic out_free;
  } stat_t;

  function automatic logic signed [TREND_W-1:0] sat_trend(input logic signed [RND_W-1:0] v);
    logic signed [TREND_W-1:0] r;
    if (v > SAT_HI) begin
      r = TREND_MAX;
    end else if (v < SAT_LO) begin
      r = TREND_MIN;
    end else begin
      r = v[TREND_W-1:0];
    end
    return r;
  endfunction

endpackage

[rtl/itf_mul.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// itf_mul
// Shared signed multiplier with a registered product.
// ----------------------------------------------------------------------------
module itf_mul (
  input  logic                                clk,
  input  logic signed [itf_pkg::MUL_A_W-1:0]  op_a,
  input  logic signed [itf_pkg::MUL_B_W-1:0]  op_b,
  output logic signed [itf_pkg::PROD_W-1:0]   prod
);

  logic signed [itf_pkg::PROD_W-1:0] prod_r;

  always_ff @(posedge clk) begin
    prod_r <= op_a * op_b;
  end

  assign prod = prod_r;

endmodule

[rtl/itf_ctrl.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// itf_ctrl
// Sequencer: squares, five MAC steps, round, emit; warm-up goes to EMIT.
// ----------------------------------------------------------------------------
module itf_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  input  itf_pkg::stat_t  st,
  output itf_pkg::ctl_t   ctl
);

  itf_pkg::state_t state_r, state_nxt;
  logic [2:0]      step_r, step_nxt;
  logic            emit_go;

  assign emit_go = st.out_free || !st.has_result;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= itf_pkg::ST_IDLE;
      step_r  <= 3'd0;
    end else begin
      state_r <= state_nxt;
      step_r  <= step_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    step_nxt  = 3'd0;
    case (state_r)
      itf_pkg::ST_IDLE: begin
        if (in_valid) begin
          state_nxt = st.go_iir ? itf_pkg::ST_SQA : itf_pkg::ST_EMIT;
        end
      end
      itf_pkg::ST_SQA:   state_nxt = itf_pkg::ST_SQB;
      itf_pkg::ST_SQB:   state_nxt = itf_pkg::ST_MAC;
      itf_pkg::ST_MAC: begin
        if (step_r == 3'd4) begin
          state_nxt = itf_pkg::ST_LAST;
        end else begin
          step_nxt = step_r + 3'd1;
        end
      end
      itf_pkg::ST_LAST:  state_nxt = itf_pkg::ST_ROUND;
      itf_pkg::ST_ROUND: state_nxt = itf_pkg::ST_EMIT;
      itf_pkg::ST_EMIT: begin
        if (emit_go) begin
          state_nxt = itf_pkg::ST_IDLE;
        end
      end
      default: state_nxt = itf_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    ctl           = '0;
    ctl.mul_sel   = itf_pkg::MS_ALPHA;
    ctl.acc_op    = itf_pkg::ACC_HOLD;
    case (state_r)
      itf_pkg::ST_IDLE: begin
        ctl.ready  = 1'b1;
        ctl.accept = in_valid;
      end
      itf_pkg::ST_SQA: ctl.mul_sel = itf_pkg::MS_ALPHA;
      itf_pkg::ST_SQB: begin
        ctl.mul_sel   = itf_pkg::MS_OMA;
        ctl.ld_coef_a = 1'b1;
      end
      itf_pkg::ST_MAC: begin
        // issue product k, fold in product k-1
        case (step_r)
          3'd0: begin
            ctl.mul_sel   = itf_pkg::MS_C0;
            ctl.ld_coef_b = 1'b1;
            ctl.acc_op    = itf_pkg::ACC_CLEAR;
          end
          3'd1: begin
            ctl.mul_sel = itf_pkg::MS_C1;
            ctl.acc_op  = itf_pkg::ACC_ADD;
          end
          3'd2: begin
            ctl.mul_sel = itf_pkg::MS_C2;
            ctl.acc_op  = itf_pkg::ACC_ADD;
          end
          3'd3: begin
            ctl.mul_sel = itf_pkg::MS_C3;
            ctl.acc_op  = itf_pkg::ACC_SUB;
          end
          3'd4: begin
            ctl.mul_sel = itf_pkg::MS_C4;
            ctl.acc_op  = itf_pkg::ACC_ADD;
          end
          default: ctl.acc_op = itf_pkg::ACC_HOLD;
        endcase
      end
      itf_pkg::ST_LAST:  ctl.acc_op   = itf_pkg::ACC_SUB;
      itf_pkg::ST_ROUND: ctl.ld_round = 1'b1;
      itf_pkg::ST_EMIT:  ctl.emit     = emit_go;
      default:           ctl.ready    = 1'b0;
    endcase
  end

endmodule

[rtl/instantaneous_trendline_filter.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// instantaneous_trendline_filter
// Trendline filter over median price words with a configurable alpha.
// ----------------------------------------------------------------------------
// Usage:
//   in_valid/in_stall/in_data carry one median price word and a first flag;
//   a word is taken when in_valid is high and in_stall low. out_valid/
//   out_stall/out_data return trend, trigger and trigger_valid. Samples 0
//   and 1 of a series give no output word.
//   cfg_valid/cfg_ready/cfg_data write alpha (Q0.16); write it only while idle.
// Timing:
//   Warm-up samples are loaded into the trend register on acceptance and
//   reach the output register from EMIT. IIR samples pass SQA, SQB, MAC,
//   LAST, ROUND and EMIT, and the next word is taken only back in IDLE:
//   one shared 41x23 multiplier forms alpha^2, (1-alpha)^2 and the
//   five products in turn, then the sum is rounded and saturated.
// Reset:
//   rst_n clears the history, the sample index and the output valid, and
//   loads alpha with 0.07.
// Stall:
//   A word held in the output register waits under out_stall; the filter
//   finishes the current sample and holds in EMIT until the register frees.
// ----------------------------------------------------------------------------
module instantaneous_trendline_filter (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  itf_pkg::in_t                  in_data,
  output logic                          out_valid,
  input  logic                          out_stall,
  output itf_pkg::out_t                 out_data,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [itf_pkg::ALPHA_W-1:0]   cfg_data
);

  itf_pkg::ctl_t  ctl;
  itf_pkg::stat_t st;

  logic [itf_pkg::ALPHA_W-1:0]           alpha_r;
  logic [itf_pkg::IDX_W-1:0]             idx_r, cur_idx_r, cur_idx;
  logic [itf_pkg::PRICE_W-1:0]           m_r, m1_r, m2_r;
  logic signed [itf_pkg::TREND_W-1:0]    t1_r, t2_r, trend_r;
  logic [itf_pkg::COEF_W-1:0]            c0_r, c1_r, c2_r, c3_r, c4_r;
  logic signed [itf_pkg::PROD_W-1:0]     acc_r, prod, acc_rnd;
  logic signed [itf_pkg::RND_W-1:0]      rnd_q, trig_w;
  logic signed [itf_pkg::MUL_A_W-1:0]    op_a;
  logic signed [itf_pkg::MUL_B_W-1:0]    op_b;
  logic [16:0]                           oma;
  logic [33:0]                           fir_sum;
  logic [34:0]                           aq, a2_35, a2x3, c0_full, c2_full;
  logic [32:0]                           c1_full;
  logic [33:0]                           c4_full;
  itf_pkg::out_t                         out_r;
  logic                                  out_valid_r;

  assign cfg_ready = 1'b1;
  assign in_stall  = !ctl.ready;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  assign cur_idx       = in_data.first ? '0 : idx_r;
  assign st.go_iir     = cur_idx >= itf_pkg::WARMUP_SAMPLES;
  assign st.has_result = cur_idx_r >= itf_pkg::IDX_FIR_START;
  assign st.out_free   = !out_valid_r || !out_stall;

  itf_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .st       (st),
    .ctl      (ctl)
  );

  // ---- shared multiplier ----
  assign oma = 17'h10000 - {1'b0, alpha_r};

  always_comb begin
    case (ctl.mul_sel)
      itf_pkg::MS_ALPHA: begin
        op_a = {25'd0, alpha_r};
        op_b = {7'd0, alpha_r};
      end
      itf_pkg::MS_OMA: begin
        op_a = {24'd0, oma};
        op_b = {6'd0, oma};
      end
      itf_pkg::MS_C0: begin
        op_a = {9'd0, m_r};
        op_b = {1'b0, c0_r};
      end
      itf_pkg::MS_C1: begin
        op_a = {9'd0, m1_r};
        op_b = {1'b0, c1_r};
      end
      itf_pkg::MS_C2: begin
        op_a = {9'd0, m2_r};
        op_b = {1'b0, c2_r};
      end
      itf_pkg::MS_C3: begin
        op_a = {t1_r[itf_pkg::TREND_W-1], t1_r};
        op_b = {1'b0, c3_r};
      end
      itf_pkg::MS_C4: begin
        op_a = {t2_r[itf_pkg::TREND_W-1], t2_r};
        op_b = {1'b0, c4_r};
      end
      default: begin
        op_a = '0;
        op_b = '0;
      end
    endcase
  end

  itf_mul u_mul (
    .clk  (clk),
    .op_a (op_a),
    .op_b (op_b),
    .prod (prod)
  );

  // ---- coefficients in Q.20, c0/c2 rounded half up from Q.34, c1 from Q.33, c4 from Q.32 ----
  assign aq      = {1'b0, alpha_r, 18'd0};
  assign a2_35   = {3'd0, prod[31:0]};
  assign a2x3    = a2_35 + {2'd0, prod[31:0], 1'b0};
  assign c0_full = aq - a2_35 + 35'd8192;
  assign c2_full = aq - a2x3 + 35'd8192;
  assign c1_full = {1'b0, prod[31:0]} + 33'd4096;
  assign c4_full = {1'b0, prod[32:0]} + 34'd2048;

  always_ff @(posedge clk) begin
    if (ctl.ld_coef_a) begin
      c0_r <= {1'b0, c0_full[34:14]};
      c1_r <= {2'd0, c1_full[32:13]};
      c2_r <= {1'b0, c2_full[34:14]};
      c3_r <= {oma, 5'd0};
    end
    if (ctl.ld_coef_b) begin
      c4_r <= c4_full[33:12];
    end
  end

  // ---- accumulator, rounding ----
  assign acc_rnd = acc_r + itf_pkg::ROUND_BIAS;
  assign rnd_q   = acc_rnd[itf_pkg::PROD_W-1:itf_pkg::COEF_FRAC];

  always_ff @(posedge clk) begin
    case (ctl.acc_op)
      itf_pkg::ACC_CLEAR: acc_r <= '0;
      itf_pkg::ACC_ADD:   acc_r <= acc_r + prod;
      itf_pkg::ACC_SUB:   acc_r <= acc_r - prod;
      default:            acc_r <= acc_r;
    endcase
  end

  assign fir_sum = {2'd0, in_data.median_price} + {1'b0, m1_r, 1'b0} + {2'd0, m2_r} + 34'd2;

  always_ff @(posedge clk) begin
    if (ctl.accept) begin
      m_r       <= in_data.median_price;
      cur_idx_r <= cur_idx;
      // pass through for the first two samples, FIR during warm-up
      if (cur_idx < itf_pkg::IDX_FIR_START) begin
        trend_r <= {8'd0, in_data.median_price};
      end else begin
        trend_r <= {8'd0, fir_sum[33:2]};
      end
    end else if (ctl.ld_round) begin
      trend_r <= itf_pkg::sat_trend(rnd_q);
    end
  end

  // ---- history and configuration ----
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      alpha_r <= itf_pkg::ALPHA_RESET;
      idx_r   <= '0;
      m1_r    <= '0;
      m2_r    <= '0;
      t1_r    <= '0;
      t2_r    <= '0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        alpha_r <= cfg_data;
      end
      if (ctl.emit) begin
        m2_r  <= m1_r;
        m1_r  <= m_r;
        t2_r  <= t1_r;
        t1_r  <= trend_r;
        idx_r <= (cur_idx_r < itf_pkg::IDX_MAX) ? cur_idx_r + 3'd1 : itf_pkg::IDX_MAX;
      end
    end
  end

  // ---- output register ----
  assign trig_w = {{3{trend_r[itf_pkg::TREND_W-1]}}, trend_r, 1'b0}
                - {{4{t2_r[itf_pkg::TREND_W-1]}}, t2_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (ctl.emit && st.has_result) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.emit && st.has_result) begin
      out_r.trend_value <= trend_r;
      if (cur_idx_r >= itf_pkg::IDX_TRIG_START) begin
        out_r.trigger_value <= itf_pkg::sat_trend(trig_w);
        out_r.trigger_valid <= 1'b1;
      end else begin
        out_r.trigger_value <= '0;
        out_r.trigger_valid <= 1'b0;
      end
    end
  end

`ifndef SYNTH
  a_busy_after_accept : assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("input accepted twice in a row");

  a_trigger_zero : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.trigger_valid || out_data.trigger_value == '0))
    else $error("trigger value set without trigger_valid");

  a_emit_shows : assert property (@(posedge clk) disable iff (!rst_n)
    ctl.emit && st.has_result |=> out_valid)
    else $error("emitted word not presented");
`endif

endmodule
